// ===== sv/lpbi_pkg.sv =====
// Package for the line polynomial boundary interpolator: widths, pipeline
// stage map, the interpolation order codes and the square-root step function.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package lpbi_pkg;

  // Component and packed-field widths.
  localparam int CW   = 21;
  localparam int PW   = 3 * CW;
  localparam int DW   = CW + 1;        // component difference
  localparam int SQW  = 2 * CW + 1;    // square of a difference
  localparam int SUMW = SQW + 1;       // sum of three squares

  // Digit-by-digit square root.
  localparam int SQX      = 48;        // radicand, zero extended
  localparam int SQ_RT    = SQX / 2;
  localparam int SQ_RM    = SQ_RT + 2;
  localparam int SQ_STEPS = 4;         // root bits per stage
  localparam int SQ_STG   = SQ_RT / SQ_STEPS;
  localparam int RTW      = CW + 1;    // distance width

  // Polynomial terms.
  localparam int RW    = RTW + 1;      // r = d1 + d2
  localparam int RMSW  = RW + 1;       // r - s
  localparam int SMDW  = RTW + 1;      // s - d1
  localparam int P1W   = DW + RW;      // u * r
  localparam int LINW  = DW + RTW;     // u * s
  localparam int DDW   = 2 * RTW;      // d1 * d2
  localparam int SPL   = 23;           // split point of the wide products
  localparam int NUMW  = 70;
  localparam int NSPL  = 24;           // split point of num * s
  localparam int DENW  = DDW + RW + 1;
  localparam int NW    = 96;
  localparam int QW    = 23;           // quotient bits kept before saturation
  localparam int DIV_STEPS = QW;

  // Pipeline stage map.
  localparam int ST_IN   = 0;
  localparam int ST_SQR  = 1;
  localparam int ST_SUM  = 2;
  localparam int ST_SQ0  = 3;
  localparam int ST_A    = ST_SQ0 + SQ_STG;
  localparam int ST_B    = ST_A + 1;
  localparam int ST_C    = ST_B + 1;
  localparam int ST_D    = ST_C + 1;
  localparam int ST_E    = ST_D + 1;
  localparam int ST_F    = ST_E + 1;
  localparam int ST_G    = ST_F + 1;
  localparam int ST_H    = ST_G + 1;
  localparam int ST_I    = ST_H + 1;
  localparam int ST_DIV0 = ST_I + 1;
  localparam int ST_OUT  = ST_DIV0 + DIV_STEPS;
  localparam int N_STG   = ST_OUT + 1;

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [1:0] {
    ORD_COPY   = 2'd0,
    ORD_LINEAR = 2'd1,
    ORD_QUAD   = 2'd2,
    ORD_QUAD3  = 2'd3
  } order_e;

  typedef struct packed {
    logic [SQX-1:0]   x;
    logic [SQ_RM-1:0] rem;
    logic [SQ_RT-1:0] root;
  } sq_t;

  function automatic logic signed [CW-1:0] comp_of(input logic [PW-1:0] f,
                                                    input int unsigned k);
    return $signed(f[k*CW +: CW]);
  endfunction

  // Several restoring square-root steps: two radicand bits per root bit.
  function automatic sq_t sqrt_steps(input sq_t s_in);
    sq_t s;
    logic [SQ_RM+1:0] rem2;
    logic [SQ_RM+1:0] trial;
    s = s_in;
    for (int i = 0; i < SQ_STEPS; i++) begin
      rem2  = {s.rem, s.x[SQX-1 -: 2]};
      trial = (SQ_RM+2)'({s.root, 2'b01});
      if (rem2 >= trial) begin
        s.rem  = SQ_RM'(rem2 - trial);
        s.root = {s.root[SQ_RT-2:0], 1'b1};
      end else begin
        s.rem  = SQ_RM'(rem2);
        s.root = {s.root[SQ_RT-2:0], 1'b0};
      end
      s.x = {s.x[SQX-3:0], 2'b00};
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== sv/line_poly_boundary_interp.sv =====
// Line polynomial boundary interpolator. An input beat carries one boundary
// cell: boundary point and value, cell center, two samples on the normal
// line with their values, and the number of valid samples (0 copies the
// boundary value, 1 fits a line, 2 or 3 fit a quadratic). One output beat
// carries the saturated x, y and z cell values.
// Both channels use valid/ready. The datapath is a 42-stage pipeline, and
// one beat can be accepted every cycle while out_ready_i stays high. The
// three distance square roots take 6 stages at 4 root bits each, and the
// divider 23 stages at one quotient bit each; those two units set the
// latency.
// When the receiver holds ready low, the output register keeps its result
// and the stages behind it keep filling their empty slots before in_ready_o
// drops, so no beat is lost or repeated.
// Reset clears all valid bits; the pipeline is empty and ready afterward.
// Depends on lpbi_pkg, lpbi_pipe_ctrl and lpbi_div.
`default_nettype none

module line_poly_boundary_interp import lpbi_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           valid_samples_i,
  input  wire logic [PW-1:0]        boundary_point_i,
  input  wire logic [PW-1:0]        boundary_value_i,
  input  wire logic [PW-1:0]        cell_center_i,
  input  wire logic [PW-1:0]        near_point_i,
  input  wire logic [PW-1:0]        near_value_i,
  input  wire logic [PW-1:0]        far_point_i,
  input  wire logic [PW-1:0]        far_value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [CW-1:0]      cell_value_x_o,
  output logic signed [CW-1:0]      cell_value_y_o,
  output logic signed [CW-1:0]      cell_value_z_o
);

  logic [N_STG-1:0] ld, vld;

  lpbi_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .ld_o        (ld),
    .vld_o       (vld)
  );

  // Carried fields.
  logic signed [CW-1:0] base_q  [ST_OUT][3];
  logic [1:0]           order_q [ST_G];
  logic signed [DW-1:0] u1_q    [ST_A+1][3];
  logic signed [DW-1:0] u2_q    [ST_A+1][3];

  // Distances: 0 is cell to boundary, 1 near sample to boundary, 2 far to near.
  logic signed [DW-1:0] dif_q [3][3];
  logic [SQW-1:0]       sq_q  [3][3];
  logic [SUMW-1:0]      sum_q [3];
  sq_t                  sqs_q  [SQ_STG][3];
  sq_t                  sqs_in [SQ_STG][3];
  logic [RTW-1:0]       rt [3];

  always_ff @(posedge clk_i) begin
    if (ld[ST_IN]) begin
      order_q[0] <= valid_samples_i;
      for (int l = 0; l < 3; l++) begin
        base_q[0][l] <= comp_of(boundary_value_i, l);
        u1_q[0][l]   <= DW'(comp_of(near_value_i, l)) - DW'(comp_of(boundary_value_i, l));
        u2_q[0][l]   <= DW'(comp_of(far_value_i, l)) - DW'(comp_of(boundary_value_i, l));
        dif_q[0][l]  <= DW'(comp_of(cell_center_i, l)) - DW'(comp_of(boundary_point_i, l));
        dif_q[1][l]  <= DW'(comp_of(near_point_i, l)) - DW'(comp_of(boundary_point_i, l));
        dif_q[2][l]  <= DW'(comp_of(far_point_i, l)) - DW'(comp_of(near_point_i, l));
      end
    end
    for (int k = 1; k < ST_OUT; k++) begin
      if (ld[k]) begin
        base_q[k] <= base_q[k-1];
      end
    end
    for (int k = 1; k < ST_G; k++) begin
      if (ld[k]) begin
        order_q[k] <= order_q[k-1];
      end
    end
    for (int k = 1; k <= ST_A; k++) begin
      if (ld[k]) begin
        u1_q[k] <= u1_q[k-1];
        u2_q[k] <= u2_q[k-1];
      end
    end
  end

  // Squares, then their sums.
  always_ff @(posedge clk_i) begin
    logic signed [2*DW-1:0] p;
    p = '0;
    if (ld[ST_SQR]) begin
      for (int d = 0; d < 3; d++) begin
        for (int l = 0; l < 3; l++) begin
          p = dif_q[d][l] * dif_q[d][l];
          sq_q[d][l] <= p[SQW-1:0];
        end
      end
    end
    if (ld[ST_SUM]) begin
      for (int d = 0; d < 3; d++) begin
        sum_q[d] <= SUMW'(sq_q[d][0]) + SUMW'(sq_q[d][1]) + SUMW'(sq_q[d][2]);
      end
    end
  end

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      sqs_in[0][d].x    = SQX'(sum_q[d]);
      sqs_in[0][d].rem  = '0;
      sqs_in[0][d].root = '0;
      for (int k = 1; k < SQ_STG; k++) begin
        sqs_in[k][d] = sqs_q[k-1][d];
      end
      rt[d] = sqs_q[SQ_STG-1][d].root[RTW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < SQ_STG; k++) begin
      if (ld[ST_SQ0+k]) begin
        for (int d = 0; d < 3; d++) begin
          sqs_q[k][d] <= sqrt_steps(sqs_in[k][d]);
        end
      end
    end
  end

  // Stage A: line coordinates r, r - s and s - d1.
  logic [RTW-1:0]        s_q [ST_E-ST_A+1];
  logic [RTW-1:0]        d1_a_q, d2_a_q;
  logic [RW-1:0]         r_a_q;
  logic signed [RMSW-1:0] rms_a_q;
  logic signed [SMDW-1:0] smd_a_q;

  always_ff @(posedge clk_i) begin
    if (ld[ST_A]) begin
      s_q[0]  <= rt[0];
      d1_a_q  <= rt[1];
      d2_a_q  <= rt[2];
      r_a_q   <= RW'(rt[1]) + RW'(rt[2]);
      rms_a_q <= RMSW'(rt[1]) + RMSW'(rt[2]) - RMSW'(rt[0]);
      smd_a_q <= SMDW'(rt[0]) - SMDW'(rt[1]);
    end
    for (int k = ST_A + 1; k <= ST_E; k++) begin
      if (ld[k]) begin
        s_q[k-ST_A] <= s_q[k-ST_A-1];
      end
    end
  end

  // Stage B: first products.
  logic signed [P1W-1:0]  p1_q [3];
  logic signed [P1W-1:0]  p2_q [3];
  logic signed [LINW-1:0] lin_q [ST_F-ST_B+1][3];
  logic [RW-1:0]          dl_q  [ST_F-ST_B+1];
  logic [DDW-1:0]         dd_q;
  logic [RW-1:0]          r_b_q;
  logic signed [RMSW-1:0] rms_b_q;
  logic signed [SMDW-1:0] smd_b_q;

  always_ff @(posedge clk_i) begin
    if (ld[ST_B]) begin
      for (int l = 0; l < 3; l++) begin
        p1_q[l]     <= u1_q[ST_A][l] * $signed({1'b0, r_a_q});
        p2_q[l]     <= u2_q[ST_A][l] * $signed({2'b00, d1_a_q});
        lin_q[0][l] <= u1_q[ST_A][l] * $signed({1'b0, s_q[ST_A-ST_A]});
      end
      dl_q[0] <= RW'(d1_a_q) + RW'(1);
      dd_q    <= d1_a_q * d2_a_q;
      r_b_q   <= r_a_q;
      rms_b_q <= rms_a_q;
      smd_b_q <= smd_a_q;
    end
    for (int k = ST_B + 1; k <= ST_F; k++) begin
      if (ld[k]) begin
        lin_q[k-ST_B] <= lin_q[k-ST_B-1];
        dl_q[k-ST_B]  <= dl_q[k-ST_B-1];
      end
    end
  end

  // Stage C: partial products of the wide terms, split at bit SPL.
  logic signed [RMSW+P1W-SPL-1:0] a_hi_q [3];
  logic signed [RMSW+SPL:0]       a_lo_q [3];
  logic signed [RMSW+P1W-SPL-1:0] b_hi_q [3];
  logic signed [RMSW+SPL:0]       b_lo_q [3];
  logic [DDW-SPL+RW-1:0]          dd_hi_q;
  logic [SPL+RW-1:0]              dd_lo_q;

  always_ff @(posedge clk_i) begin
    if (ld[ST_C]) begin
      for (int l = 0; l < 3; l++) begin
        a_hi_q[l] <= $signed(p1_q[l][P1W-1:SPL]) * rms_b_q;
        a_lo_q[l] <= $signed({1'b0, p1_q[l][SPL-1:0]}) * rms_b_q;
        b_hi_q[l] <= $signed(p2_q[l][P1W-1:SPL]) * smd_b_q;
        b_lo_q[l] <= $signed({1'b0, p2_q[l][SPL-1:0]}) * smd_b_q;
      end
      dd_hi_q <= dd_q[DDW-1:SPL] * r_b_q;
      dd_lo_q <= dd_q[SPL-1:0] * r_b_q;
    end
  end

  // Stage D: recombine; stage E: numerator sum.
  logic signed [NUMW-1:0] t1_q [3];
  logic signed [NUMW-1:0] t2_q [3];
  logic signed [NUMW-1:0] num_q [3];
  logic [DENW-1:0]        den_d_q, den_e_q, den_f_q;

  always_ff @(posedge clk_i) begin
    if (ld[ST_D]) begin
      for (int l = 0; l < 3; l++) begin
        t1_q[l] <= (NUMW'(a_hi_q[l]) <<< SPL) + NUMW'(a_lo_q[l]);
        t2_q[l] <= (NUMW'(b_hi_q[l]) <<< SPL) + NUMW'(b_lo_q[l]);
      end
      den_d_q <= (DENW'(dd_hi_q) << SPL) + DENW'(dd_lo_q) + DENW'(1);
    end
    if (ld[ST_E]) begin
      for (int l = 0; l < 3; l++) begin
        num_q[l] <= t1_q[l] + t2_q[l];
      end
      den_e_q <= den_d_q;
    end
  end

  // Stage F: numerator times s in three slices.
  logic [NSPL+RTW-1:0]          np0_q [3];
  logic [NSPL+RTW-1:0]          np1_q [3];
  logic signed [NUMW-2*NSPL+RTW:0] np2_q [3];

  always_ff @(posedge clk_i) begin
    if (ld[ST_F]) begin
      for (int l = 0; l < 3; l++) begin
        np0_q[l] <= num_q[l][NSPL-1:0] * s_q[ST_E-ST_A];
        np1_q[l] <= num_q[l][2*NSPL-1:NSPL] * s_q[ST_E-ST_A];
        np2_q[l] <= $signed(num_q[l][NUMW-1:2*NSPL]) * $signed({1'b0, s_q[ST_E-ST_A]});
      end
      den_f_q <= den_e_q;
    end
  end

  // Stage G: numerator and divisor by order.
  logic signed [NW-1:0] n_q [3];
  logic [DENW-1:0]      dv_g_q, dv_h_q, dv_i_q;

  always_ff @(posedge clk_i) begin
    if (ld[ST_G]) begin
      case (order_e'(order_q[ST_F]))
        ORD_COPY: begin
          for (int l = 0; l < 3; l++) begin
            n_q[l] <= '0;
          end
          dv_g_q <= DENW'(1);
        end
        ORD_LINEAR: begin
          for (int l = 0; l < 3; l++) begin
            n_q[l] <= NW'(lin_q[ST_F-ST_B][l]);
          end
          dv_g_q <= DENW'(dl_q[ST_F-ST_B]);
        end
        default: begin
          for (int l = 0; l < 3; l++) begin
            n_q[l] <= (NW'(np2_q[l]) <<< (2*NSPL)) + (NW'(np1_q[l]) << NSPL)
                      + NW'(np0_q[l]);
          end
          dv_g_q <= den_f_q;
        end
      endcase
    end
  end

  // Stage H: magnitude and sign; stage I: saturation test.
  logic [NW-1:0] mag_h_q [3];
  logic [NW-1:0] mag_i_q [3];
  logic          neg_q [ST_OUT-ST_H][3];
  logic          big_q [ST_OUT-ST_I][3];

  always_ff @(posedge clk_i) begin
    if (ld[ST_H]) begin
      for (int l = 0; l < 3; l++) begin
        neg_q[0][l] <= n_q[l][NW-1];
        mag_h_q[l]  <= n_q[l][NW-1] ? NW'(-n_q[l]) : NW'(n_q[l]);
      end
      dv_h_q <= dv_g_q;
    end
    if (ld[ST_I]) begin
      for (int l = 0; l < 3; l++) begin
        mag_i_q[l]  <= mag_h_q[l];
        big_q[0][l] <= mag_h_q[l] >= (NW'(dv_h_q) << QW);
      end
      dv_i_q <= dv_h_q;
    end
    for (int k = ST_H + 1; k < ST_OUT; k++) begin
      if (ld[k]) begin
        neg_q[k-ST_H] <= neg_q[k-ST_H-1];
      end
    end
    for (int k = ST_I + 1; k < ST_OUT; k++) begin
      if (ld[k]) begin
        big_q[k-ST_I] <= big_q[k-ST_I-1];
      end
    end
  end

  logic [QW-1:0] quo [3];

  lpbi_div u_div (
    .clk_i (clk_i),
    .ld_i  (ld[ST_DIV0 +: DIV_STEPS]),
    .mag_i (mag_i_q),
    .den_i (dv_i_q),
    .quo_o (quo)
  );

  // Output stage: add the boundary value and saturate.
  logic signed [CW-1:0] res_d [3];
  logic signed [CW-1:0] res_q [3];

  always_comb begin
    logic signed [QW+2:0] v;
    v = '0;
    for (int l = 0; l < 3; l++) begin
      v = (QW+3)'(base_q[ST_OUT-1][l])
          + (neg_q[ST_OUT-ST_H-1][l] ? -(QW+3)'(quo[l]) : (QW+3)'(quo[l]));
      if (big_q[ST_OUT-ST_I-1][l]) begin
        res_d[l] = neg_q[ST_OUT-ST_H-1][l] ? CMIN : CMAX;
      end else if (v > (QW+3)'(CMAX)) begin
        res_d[l] = CMAX;
      end else if (v < (QW+3)'(CMIN)) begin
        res_d[l] = CMIN;
      end else begin
        res_d[l] = v[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[ST_OUT]) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = vld[ST_OUT];
  assign cell_value_x_o = res_q[0];
  assign cell_value_y_o = res_q[1];
  assign cell_value_z_o = res_q[2];

endmodule

`default_nettype wire

// ===== sv/lpbi_pipe_ctrl.sv =====
// Valid bits and per-stage load enables of the interpolator pipeline.
// A stage loads when it is empty or the stage after it moves; uses lpbi_pkg.
`default_nettype none

module lpbi_pipe_ctrl import lpbi_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             out_ready_i,
  output logic                  in_ready_o,
  output logic [N_STG-1:0]      ld_o,
  output logic [N_STG-1:0]      vld_o
);

  logic [N_STG-1:0] vld_q, vld_d, rdy;

  // Bubbles collapse: an empty stage takes a beat even when the output stalls.
  always_comb begin
    rdy[N_STG-1] = !vld_q[N_STG-1] || out_ready_i;
    for (int k = N_STG - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < N_STG; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o = rdy[0];
  assign ld_o       = rdy;
  assign vld_o      = vld_q;

endmodule

`default_nettype wire

// ===== sv/lpbi_div.sv =====
// Pipelined restoring divider for the three components: one quotient bit per
// stage, shared divisor. Uses lpbi_pkg for widths and step count.
`default_nettype none

module lpbi_div import lpbi_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic [DIV_STEPS-1:0] ld_i,
  input  wire logic [NW-1:0]       mag_i [3],
  input  wire logic [DENW-1:0]     den_i,
  output logic      [QW-1:0]       quo_o [3]
);

  logic [NW-1:0]   rem_q [DIV_STEPS][3];
  logic [NW-1:0]   rem_d [DIV_STEPS][3];
  logic [NW-1:0]   rem_in [DIV_STEPS][3];
  logic [DENW-1:0] den_q [DIV_STEPS];
  logic [DENW-1:0] den_in [DIV_STEPS];
  logic [QW-1:0]   quo_q [DIV_STEPS][3];
  logic [QW-1:0]   quo_d [DIV_STEPS][3];
  logic [QW-1:0]   quo_in [DIV_STEPS][3];

  always_comb begin
    den_in[0] = den_i;
    for (int l = 0; l < 3; l++) begin
      rem_in[0][l] = mag_i[l];
      quo_in[0][l] = '0;
    end
    for (int j = 1; j < DIV_STEPS; j++) begin
      den_in[j] = den_q[j-1];
      for (int l = 0; l < 3; l++) begin
        rem_in[j][l] = rem_q[j-1][l];
        quo_in[j][l] = quo_q[j-1][l];
      end
    end
  end

  // Step j tests the divisor shifted to quotient bit QW-1-j.
  always_comb begin
    logic [NW-1:0] trial;
    trial = '0;
    for (int j = 0; j < DIV_STEPS; j++) begin
      trial = NW'(den_in[j]) << (QW - 1 - j);
      for (int l = 0; l < 3; l++) begin
        if (rem_in[j][l] >= trial) begin
          rem_d[j][l] = rem_in[j][l] - trial;
          quo_d[j][l] = {quo_in[j][l][QW-2:0], 1'b1};
        end else begin
          rem_d[j][l] = rem_in[j][l];
          quo_d[j][l] = {quo_in[j][l][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (ld_i[j]) begin
        den_q[j] <= den_in[j];
        rem_q[j] <= rem_d[j];
        quo_q[j] <= quo_d[j];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      quo_o[l] = quo_q[DIV_STEPS-1][l];
    end
  end

endmodule

`default_nettype wire
